@@ src/synth_voice_allocator_with_stealing_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared property shorthands for the voice allocator checks.
// ----------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_WITH_STEALING_UNIT_DEFINES_SVH
`define SYNTH_VOICE_ALLOCATOR_WITH_STEALING_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SVAC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SVAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/svac_pkg.sv @@
// ----------------------------------------------------------------------------
// Voice allocator package
// Types, constants and helpers shared by the voice allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svac_pkg;

   localparam int NUM_VOICES  = 16;
   localparam int VID_W       = $clog2(NUM_VOICES);
   localparam int STAMP_W     = 32;
   localparam int STAMP_RESET = 16;

   typedef enum logic [1:0] {
      LIST_FREE  = 2'd0,
      LIST_ALLOC = 2'd1,
      LIST_LAME  = 2'd2
   } list_type;

   typedef enum logic [2:0] {
      REQ_ALLOC   = 3'd0,
      REQ_FREE    = 3'd1,
      REQ_RELEASE = 3'd2,
      REQ_COLLECT = 3'd3,
      REQ_SETPRIO = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] req_priority;
      logic [7:0] owner_id;
      logic [3:0] voice_index;
      logic       updates_free;
   } req_word_type;

   typedef struct packed {
      logic       granted;
      logic [3:0] voice_out;
      logic       stolen;
      logic       evicted_valid;
      logic [7:0] evicted_owner;
      logic       deferred;
   } rsp_word_type;

   // one voice as seen through the shared read port
   typedef struct packed {
      list_type           list;
      logic               owned;
      logic               fading;
      logic [7:0]         prio;
      logic [STAMP_W-1:0] stamp;
   } voice_view_type;

   typedef struct packed {
      logic             lame_found;
      logic [VID_W-1:0] lame_vid;
      logic             free_found;
      logic [VID_W-1:0] free_vid;
      logic             vic_found;
      logic [VID_W-1:0] vic_vid;
   } scan_best_type;

   typedef struct packed {
      logic             busy;
      logic             load;
      logic             scan_clear;
      logic             scan_step;
      logic             exec;
      logic [VID_W-1:0] scan_vid;
   } ctrl_type;

   function automatic logic [3:0] vid_to_out(input logic [VID_W-1:0] v);
      logic [VID_W+3:0] w;
      w = {4'b0000, v};
      return w[3:0];
   endfunction

   function automatic logic [VID_W-1:0] idx_to_vid(input logic [3:0] i);
      logic [VID_W+3:0] w;
      w = {{VID_W{1'b0}}, i};
      return w[VID_W-1:0];
   endfunction

   function automatic logic idx_in_pool(input logic [3:0] i);
      logic [VID_W+3:0] w;
      w = {{VID_W{1'b0}}, i};
      return w < (VID_W+4)'(NUM_VOICES);
   endfunction

endpackage

@@ src/svac_scan.sv @@
// ----------------------------------------------------------------------------
// Voice allocator scan unit
// Age subtractor and compare unit, one voice per step, holding the newest
// lame, newest free and best steal candidate seen so far.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svac_scan
   import svac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               scan_clear,
   input  logic               scan_step,
   input  logic [VID_W-1:0]   scan_vid,
   input  voice_view_type     view,
   input  logic [STAMP_W-1:0] stamp_next,
   input  logic [7:0]         req_prio,
   output scan_best_type      best
);

   logic               lame_found_ff, lame_found_in;
   logic [VID_W-1:0]   lame_vid_ff, lame_vid_in;
   logic [STAMP_W-1:0] lame_age_ff, lame_age_in;
   logic               free_found_ff, free_found_in;
   logic [VID_W-1:0]   free_vid_ff, free_vid_in;
   logic [STAMP_W-1:0] free_age_ff, free_age_in;
   logic               vic_found_ff, vic_found_in;
   logic [VID_W-1:0]   vic_vid_ff, vic_vid_in;
   logic [STAMP_W-1:0] vic_age_ff, vic_age_in;
   logic [7:0]         vic_prio_ff, vic_prio_in;

   logic [STAMP_W-1:0] age;
   logic               take_lame, take_free, take_vic;

   assign age = stamp_next - view.stamp;

   assign take_lame = (view.list == LIST_LAME) && (!lame_found_ff || age < lame_age_ff);
   assign take_free = (view.list == LIST_FREE) && (!free_found_ff || age < free_age_ff);
   assign take_vic  = (view.list == LIST_ALLOC) && view.owned && !view.fading &&
                      (view.prio <= req_prio) &&
                      (!vic_found_ff || view.prio < vic_prio_ff ||
                       (view.prio == vic_prio_ff && age > vic_age_ff));

   always_comb begin
      lame_found_in = lame_found_ff;
      lame_vid_in   = lame_vid_ff;
      lame_age_in   = lame_age_ff;
      free_found_in = free_found_ff;
      free_vid_in   = free_vid_ff;
      free_age_in   = free_age_ff;
      vic_found_in  = vic_found_ff;
      vic_vid_in    = vic_vid_ff;
      vic_age_in    = vic_age_ff;
      vic_prio_in   = vic_prio_ff;
      if (scan_clear) begin
         lame_found_in = 1'b0;
         free_found_in = 1'b0;
         vic_found_in  = 1'b0;
      end else if (scan_step) begin
         if (take_lame) begin
            lame_found_in = 1'b1;
            lame_vid_in   = scan_vid;
            lame_age_in   = age;
         end
         if (take_free) begin
            free_found_in = 1'b1;
            free_vid_in   = scan_vid;
            free_age_in   = age;
         end
         if (take_vic) begin
            vic_found_in = 1'b1;
            vic_vid_in   = scan_vid;
            vic_age_in   = age;
            vic_prio_in  = view.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lame_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff  <= 1'b0;
      end else begin
         lame_found_ff <= lame_found_in;
         free_found_ff <= free_found_in;
         vic_found_ff  <= vic_found_in;
      end
   end

   always_ff @(posedge clock) begin
      lame_vid_ff <= lame_vid_in;
      lame_age_ff <= lame_age_in;
      free_vid_ff <= free_vid_in;
      free_age_ff <= free_age_in;
      vic_vid_ff  <= vic_vid_in;
      vic_age_ff  <= vic_age_in;
      vic_prio_ff <= vic_prio_in;
   end

   assign best.lame_found = lame_found_ff;
   assign best.lame_vid   = lame_vid_ff;
   assign best.free_found = free_found_ff;
   assign best.free_vid   = free_vid_ff;
   assign best.vic_found  = vic_found_ff;
   assign best.vic_vid    = vic_vid_ff;

endmodule

@@ src/svac_ctrl.sv @@
// ----------------------------------------------------------------------------
// Voice allocator sequencer
// Steps the scan counter over the pool and hands off to the execute cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svac_ctrl
   import svac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] new_type,
   input  logic       collect_more,
   output ctrl_type   ctrl
);

   state_type        state_ff, state_in;
   logic [VID_W-1:0] cnt_ff, cnt_in;
   logic             needs_scan;
   logic             scan_last;

   assign needs_scan = (new_type == REQ_ALLOC) || (new_type == REQ_COLLECT);
   assign scan_last  = (cnt_ff == VID_W'(NUM_VOICES - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = needs_scan ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = collect_more ? ST_SCAN : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.busy       = 1'b0;
      ctrl.load       = 1'b0;
      ctrl.scan_clear = 1'b0;
      ctrl.scan_step  = 1'b0;
      ctrl.exec       = 1'b0;
      ctrl.scan_vid   = cnt_ff;
      cnt_in          = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            ctrl.load       = start;
            ctrl.scan_clear = start;
            cnt_in          = '0;
         end
         ST_SCAN: begin
            ctrl.busy      = 1'b1;
            ctrl.scan_step = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
         end
         ST_EXEC: begin
            ctrl.busy       = 1'b1;
            ctrl.exec       = 1'b1;
            ctrl.scan_clear = collect_more;
            cnt_in          = '0;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ src/synth_voice_allocator_with_stealing_unit.sv @@
// ----------------------------------------------------------------------------
// Voice allocator with stealing
// Allocates physical synth voices from lame and free lists, steals the
// lowest-priority oldest voice when the pool is exhausted.
// ----------------------------------------------------------------------------
// Usage:
//   A request word is taken on req_word at a clock edge with start high and
//   busy low. One result word per request appears on rsp_word for a single
//   cycle with rsp_valid high; the receiver cannot stall it.
//   Allocate and collect walk the pool through one age/priority compare
//   unit, one voice per cycle, then execute; the result follows on the
//   next cycle. Collect repeats the walk once per lame voice plus a final
//   one.
//   Free, release and set priority skip the walk and go straight to the execute step, result the next.
//   A new request may be started in the cycle its predecessor's result is
//   shown.
//   Reset puts every voice in the free list, stamps voice v with v and the
//   next stamp at 16, and clears owners, priorities and fade marks. No
//   clearing pass is needed; the block is ready right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "synth_voice_allocator_with_stealing_unit_defines.svh"

module synth_voice_allocator_with_stealing_unit
   import svac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   list_type           list_ff   [NUM_VOICES];
   logic [STAMP_W-1:0] stamp_ff  [NUM_VOICES];
   logic [7:0]         prio_ff   [NUM_VOICES];
   logic [7:0]         tag_ff    [NUM_VOICES];
   logic               owned_ff  [NUM_VOICES];
   logic               fading_ff [NUM_VOICES];
   logic               pend_ff   [NUM_VOICES];
   logic [STAMP_W-1:0] stamp_next_ff;

   req_word_type  req_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   ctrl_type       ctrl;
   scan_best_type  best;
   voice_view_type view;

   logic [VID_W-1:0] target_vid;
   logic [VID_W-1:0] rd_vid;
   logic             idx_ok;
   logic             collect_more;

   // write controls for the execute cycle
   logic     wr_enter;
   list_type wr_list;
   logic     wr_fading_en, wr_fading;
   logic     wr_pend_en, wr_pend;
   logic     wr_owned_en, wr_owned;
   logic     wr_tag_en;
   logic     wr_prio_en;

   svac_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .new_type     (req_word.req_type),
      .collect_more (collect_more),
      .ctrl         (ctrl)
   );

   svac_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_clear (ctrl.scan_clear),
      .scan_step  (ctrl.scan_step),
      .scan_vid   (ctrl.scan_vid),
      .view       (view),
      .stamp_next (stamp_next_ff),
      .req_prio   (req_ff.req_priority),
      .best       (best)
   );

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_word;
      end
   end

   assign idx_ok = idx_in_pool(req_ff.voice_index);

   always_comb begin
      target_vid = idx_to_vid(req_ff.voice_index);
      if (req_ff.req_type == REQ_ALLOC) begin
         if (best.lame_found) begin
            target_vid = best.lame_vid;
         end else if (best.free_found) begin
            target_vid = best.free_vid;
         end else begin
            target_vid = best.vic_vid;
         end
      end else if (req_ff.req_type == REQ_COLLECT) begin
         target_vid = best.lame_vid;
      end
   end

   assign rd_vid = ctrl.scan_step ? ctrl.scan_vid : target_vid;

   assign view.list   = list_ff[rd_vid];
   assign view.owned  = owned_ff[rd_vid];
   assign view.fading = fading_ff[rd_vid];
   assign view.prio   = prio_ff[rd_vid];
   assign view.stamp  = stamp_ff[rd_vid];

   // another walk is owed while a lame voice is left
   assign collect_more = (req_ff.req_type == REQ_COLLECT) && best.lame_found;

   always_comb begin
      wr_enter     = 1'b0;
      wr_list      = LIST_FREE;
      wr_fading_en = 1'b0;
      wr_fading    = 1'b0;
      wr_pend_en   = 1'b0;
      wr_pend      = 1'b0;
      wr_owned_en  = 1'b0;
      wr_owned     = 1'b0;
      wr_tag_en    = 1'b0;
      wr_prio_en   = 1'b0;
      rsp_word_in  = '0;
      case (req_ff.req_type)
         REQ_ALLOC: begin
            if (best.lame_found || best.free_found) begin
               wr_enter     = 1'b1;
               wr_list      = LIST_ALLOC;
               wr_fading_en = 1'b1;
               wr_fading    = 1'b0;
            end else if (best.vic_found && req_ff.updates_free) begin
               wr_fading_en              = 1'b1;
               wr_fading                 = 1'b1;
               rsp_word_in.stolen        = 1'b1;
               rsp_word_in.evicted_valid = 1'b1;
               rsp_word_in.evicted_owner = tag_ff[rd_vid];
            end
            if (best.lame_found || best.free_found ||
                (best.vic_found && req_ff.updates_free)) begin
               wr_pend_en            = 1'b1;
               wr_pend               = 1'b0;
               wr_owned_en           = 1'b1;
               wr_owned              = 1'b1;
               wr_tag_en             = 1'b1;
               wr_prio_en            = 1'b1;
               rsp_word_in.granted   = 1'b1;
               rsp_word_in.voice_out = vid_to_out(target_vid);
            end
         end
         REQ_FREE: begin
            rsp_word_in.voice_out = req_ff.voice_index;
            if (idx_ok && view.list == LIST_ALLOC && view.owned) begin
               wr_owned_en = 1'b1;
               wr_owned    = 1'b0;
               if (!view.fading) begin
                  wr_enter            = 1'b1;
                  wr_list             = LIST_LAME;
                  rsp_word_in.granted = 1'b1;
               end else begin
                  wr_pend_en           = 1'b1;
                  wr_pend              = 1'b1;
                  rsp_word_in.deferred = 1'b1;
               end
            end
         end
         REQ_RELEASE: begin
            rsp_word_in.voice_out = req_ff.voice_index;
            if (idx_ok && pend_ff[rd_vid] && view.list == LIST_ALLOC) begin
               wr_pend_en = 1'b1;
               wr_pend    = 1'b0;
               wr_enter   = 1'b1;
               wr_list    = LIST_LAME;
            end
         end
         REQ_COLLECT: begin
            if (best.lame_found) begin
               wr_enter = 1'b1;
               wr_list  = LIST_FREE;
            end
         end
         REQ_SETPRIO: begin
            rsp_word_in.voice_out = req_ff.voice_index;
            wr_prio_en            = idx_ok && view.owned;
         end
         default: begin
            rsp_word_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = ctrl.exec && !collect_more;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < NUM_VOICES; v++) begin
            list_ff[v]   <= LIST_FREE;
            stamp_ff[v]  <= STAMP_W'(v);
            prio_ff[v]   <= '0;
            tag_ff[v]    <= '0;
            owned_ff[v]  <= 1'b0;
            fading_ff[v] <= 1'b0;
            pend_ff[v]   <= 1'b0;
         end
         stamp_next_ff <= STAMP_W'(STAMP_RESET);
      end else if (ctrl.exec) begin
         if (wr_enter) begin
            list_ff[target_vid]  <= wr_list;
            stamp_ff[target_vid] <= stamp_next_ff;
            stamp_next_ff        <= stamp_next_ff + 1'b1;
         end
         if (wr_fading_en) begin
            fading_ff[target_vid] <= wr_fading;
         end
         if (wr_pend_en) begin
            pend_ff[target_vid] <= wr_pend;
         end
         if (wr_owned_en) begin
            owned_ff[target_vid] <= wr_owned;
         end
         if (wr_tag_en) begin
            tag_ff[target_vid] <= req_ff.owner_id;
         end
         if (wr_prio_en) begin
            prio_ff[target_vid] <= req_ff.req_priority;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign busy      = ctrl.busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `SVAC_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `SVAC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy,
                     busy && !rsp_valid, "request not taken")
   `SVAC_ASSERT_NOW(a_steal_grant, clock, reset, rsp_valid && rsp_word.stolen,
                    rsp_word.granted && rsp_word.evicted_valid, "steal without grant")
   `SVAC_ASSERT_NOW(a_defer_nogrant, clock, reset, rsp_valid && rsp_word.deferred,
                    !rsp_word.granted && !rsp_word.stolen, "deferred free granted")

endmodule

@@ test/synth_voice_allocator_with_stealing_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Voice allocator with stealing - testbench
// Drives allocate, free, release, collect, set-priority and undefined request words with random
// idle gaps and checks every result word against a behavioral copy of the
// voice pool kept in the testbench: list membership, entry stamps, owners,
// priorities, fade marks and deferred frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module synth_voice_allocator_with_stealing_unit_tb;
   import svac_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 40;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   rsp_word_type rsp_due[$];
   int           fail_count   = 0;
   int           quiet_cycles = 0;
   bit           no_gaps      = 1'b0;

   // pool copy
   list_type     v_list      [NUM_VOICES];
   logic [31:0]  v_stamp     [NUM_VOICES];
   logic [31:0]  next_stamp;
   logic [7:0]   v_prio      [NUM_VOICES];
   logic [7:0]   v_owner     [NUM_VOICES];
   logic         v_owned     [NUM_VOICES];
   logic         v_fading    [NUM_VOICES];
   logic         v_free_wait [NUM_VOICES];

   synth_voice_allocator_with_stealing_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void pool_reset();
      for (int v = 0; v < NUM_VOICES; v++) begin
         v_list[v]      = LIST_FREE;
         v_stamp[v]     = 32'(v);
         v_prio[v]      = '0;
         v_owner[v]     = '0;
         v_owned[v]     = 1'b0;
         v_fading[v]    = 1'b0;
         v_free_wait[v] = 1'b0;
      end
      next_stamp = 32'(STAMP_RESET);
   endfunction

   function automatic void move_to(input int v, input list_type l);
      v_list[v]  = l;
      v_stamp[v] = next_stamp;
      next_stamp = next_stamp + 32'd1;
   endfunction

   function automatic int newest_of(input list_type l);
      int          best;
      logic [31:0] best_age;
      logic [31:0] age;
      best     = -1;
      best_age = '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
         if (v_list[v] == l) begin
            age = next_stamp - v_stamp[v];
            if (best < 0 || age < best_age) begin
               best     = v;
               best_age = age;
            end
         end
      end
      return best;
   endfunction

   // updates the pool copy and returns the result word owed for w
   function automatic rsp_word_type apply_request(input req_word_type w);
      rsp_word_type r;
      int           v;
      int           idx;
      logic [31:0]  age;
      logic [31:0]  best_age;
      logic [7:0]   best_prio;
      r   = '0;
      idx = int'(w.voice_index);
      case (w.req_type)
         REQ_ALLOC: begin
            v = newest_of(LIST_LAME);
            if (v < 0) v = newest_of(LIST_FREE);
            if (v >= 0) begin
               move_to(v, LIST_ALLOC);
               v_fading[v] = 1'b0;
            end else begin
               best_age  = '0;
               best_prio = '0;
               for (int u = 0; u < NUM_VOICES; u++) begin
                  if (v_list[u] == LIST_ALLOC && v_owned[u] && !v_fading[u] &&
                      v_prio[u] <= w.req_priority) begin
                     age = next_stamp - v_stamp[u];
                     if (v < 0 || v_prio[u] < best_prio ||
                         (v_prio[u] == best_prio && age > best_age)) begin
                        v         = u;
                        best_prio = v_prio[u];
                        best_age  = age;
                     end
                  end
               end
               if (v < 0 || !w.updates_free) return r;
               r.stolen        = 1'b1;
               r.evicted_valid = 1'b1;
               r.evicted_owner = v_owner[v];
               v_fading[v]     = 1'b1;
            end
            v_free_wait[v] = 1'b0;
            v_owned[v]     = 1'b1;
            v_owner[v]     = w.owner_id;
            v_prio[v]      = w.req_priority;
            r.granted      = 1'b1;
            r.voice_out    = 4'(v);
         end
         REQ_FREE: begin
            r.voice_out = w.voice_index;
            if (idx >= NUM_VOICES || v_list[idx] != LIST_ALLOC || !v_owned[idx]) return r;
            v_owned[idx] = 1'b0;
            if (!v_fading[idx]) begin
               move_to(idx, LIST_LAME);
               r.granted = 1'b1;
            end else begin
               v_free_wait[idx] = 1'b1;
               r.deferred       = 1'b1;
            end
         end
         REQ_RELEASE: begin
            r.voice_out = w.voice_index;
            if (idx >= NUM_VOICES || !v_free_wait[idx] || v_list[idx] != LIST_ALLOC)
               return r;
            v_free_wait[idx] = 1'b0;
            move_to(idx, LIST_LAME);
         end
         REQ_COLLECT: begin
            for (int n = 0; n < NUM_VOICES; n++) begin
               v = newest_of(LIST_LAME);
               if (v < 0) break;
               move_to(v, LIST_FREE);
            end
         end
         REQ_SETPRIO: begin
            r.voice_out = w.voice_index;
            if (idx < NUM_VOICES && v_owned[idx]) v_prio[idx] = w.req_priority;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic req_word_type make_word(input logic [2:0] kind, input logic [7:0] prio,
                                              input logic [7:0] owner, input logic [3:0] idx,
                                              input logic slots);
      req_word_type w;
      w.req_type     = kind;
      w.req_priority = prio;
      w.owner_id     = owner;
      w.voice_index  = idx;
      w.updates_free = slots;
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = 0;
      if (!no_gaps && $urandom_range(99) < 25) gap = $urandom_range(1, 24);
      if (gap > 0) begin
         // idle while the block is ready
         start <= 1'b0;
         @(posedge clock);
         while (busy) @(posedge clock);
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      rsp_due.push_back(apply_request(w));
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   // result check
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (rsp_due.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result word g=%0d v=%0d s=%0d ev=%0d eo=%0d d=%0d",
                        rsp_word.granted, rsp_word.voice_out, rsp_word.stolen,
                        rsp_word.evicted_valid, rsp_word.evicted_owner, rsp_word.deferred);
            fail_count++;
         end else begin
            e = rsp_due.pop_front();
            if (rsp_word.granted !== e.granted || rsp_word.voice_out !== e.voice_out ||
                rsp_word.stolen !== e.stolen || rsp_word.evicted_valid !== e.evicted_valid ||
                rsp_word.evicted_owner !== e.evicted_owner ||
                rsp_word.deferred !== e.deferred) begin
               if (fail_count < 10)
                  $display("result word: expected %h, got %h", e, rsp_word);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("synth_voice_allocator_with_stealing_unit: mismatch");
      $finish;
   end

   // fill all 16 voices, priority extremes on the first and last request, top owner id on the first
   task automatic test_fill_pool();
      for (int i = 0; i < NUM_VOICES; i++)
         send_word(make_word(REQ_ALLOC, (i == 0) ? 8'hFF : (i == 15) ? 8'h00 : 8'(10 * i),
                             (i == 0) ? 8'hFF : 8'(i), 4'(i), 1'b1));
   endtask

   task automatic test_steal();
      send_word(make_word(REQ_ALLOC, 8'hFF, 8'h40, 4'hF, 1'b0));   // no update slots
      send_word(make_word(REQ_ALLOC, 8'd5, 8'd77, 4'h0, 1'b1));    // steals voice 0
      send_word(make_word(REQ_ALLOC, 8'd5, 8'd78, 4'h0, 1'b1));    // no victim left
   endtask

   task automatic test_free_release();
      send_word(make_word(REQ_FREE, 8'h00, 8'h00, 4'd0, 1'b0));    // fading: deferred
      send_word(make_word(REQ_RELEASE, 8'h00, 8'h00, 4'd1, 1'b0)); // nothing pending
      send_word(make_word(REQ_RELEASE, 8'hFF, 8'hFF, 4'd0, 1'b1));
      send_word(make_word(REQ_FREE, 8'h00, 8'h00, 4'd0, 1'b0));    // lame, unowned
      send_word(make_word(REQ_FREE, 8'h00, 8'h00, 4'd15, 1'b0));
   endtask

   task automatic test_set_priority();
      send_word(make_word(REQ_SETPRIO, 8'hFF, 8'h00, 4'd0, 1'b0)); // unowned
      send_word(make_word(REQ_SETPRIO, 8'hFF, 8'h00, 4'd14, 1'b0));
      send_word(make_word(REQ_SETPRIO, 8'h00, 8'hFF, 4'd13, 1'b1));
   endtask

   task automatic test_collect_and_unknown();
      send_word(make_word(REQ_ALLOC, 8'd200, 8'd9, 4'd0, 1'b1));   // newest lame
      send_word(make_word(REQ_COLLECT, 8'h00, 8'h00, 4'd0, 1'b0));
      for (int k = int'(REQ_SETPRIO) + 1; k < 8; k++)
         send_word(make_word(3'(k), 8'($urandom), 8'($urandom), 4'($urandom), 1'($urandom)));
      wait_for_results();
   endtask

   task automatic test_random(input int count);
      req_word_type w;
      int           pick;
      int           cand[$];
      for (int n = 0; n < count; n++) begin
         w = make_word(REQ_ALLOC, 8'($urandom), 8'($urandom), 4'($urandom),
                       1'($urandom_range(99) < 85));
         cand.delete();
         pick = $urandom_range(99);
         if (pick < 38) begin
            w.req_type = REQ_ALLOC;
         end else if (pick < 60) begin
            w.req_type = REQ_FREE;
            for (int u = 0; u < NUM_VOICES; u++)
               if (v_list[u] == LIST_ALLOC && v_owned[u]) cand.push_back(u);
            if (cand.size() != 0 && $urandom_range(99) < 75)
               w.voice_index = 4'(cand[$urandom_range(cand.size() - 1)]);
         end else if (pick < 70) begin
            w.req_type = REQ_RELEASE;
            for (int u = 0; u < NUM_VOICES; u++)
               if (v_free_wait[u]) cand.push_back(u);
            if (cand.size() != 0 && $urandom_range(99) < 75)
               w.voice_index = 4'(cand[$urandom_range(cand.size() - 1)]);
         end else if (pick < 78) begin
            w.req_type = REQ_COLLECT;
         end else if (pick < 96) begin
            w.req_type = REQ_SETPRIO;
            for (int u = 0; u < NUM_VOICES; u++)
               if (v_owned[u]) cand.push_back(u);
            if (cand.size() != 0 && $urandom_range(99) < 60)
               w.voice_index = 4'(cand[$urandom_range(cand.size() - 1)]);
         end else begin
            w.req_type = 3'($urandom_range(int'(REQ_SETPRIO) + 1, 7));
         end
         send_word(w);
         if ($urandom_range(199) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_word <= '0;
      pool_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_pool();
      test_steal();
      test_free_release();
      test_set_priority();
      test_collect_and_unknown();
      test_random(600);
      no_gaps = 1'b1;
      test_random(400);
      no_gaps = 1'b0;
      test_random(500);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && rsp_due.size() == 0) begin
         $display("synth_voice_allocator_with_stealing_unit: match");
      end else begin
         $display("synth_voice_allocator_with_stealing_unit: mismatch");
      end
      $finish;
   end

endmodule
